[src/nearest_resize_index_map_assert.svh]
// Assertion macros shared by the resize index map RTL.
`ifndef NEAREST_RESIZE_INDEX_MAP_ASSERT_SVH
`define NEAREST_RESIZE_INDEX_MAP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define NRIM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define NRIM_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

[src/nrim_pkg.sv]
// ----------------------------------------------------------------------------
// nrim_pkg
// Shared types, constants and helpers for the resize index map.
// ----------------------------------------------------------------------------
`default_nettype none
package nrim_pkg;

	localparam int NUM_DIMS  = 4;
	localparam int MAX_DIMS  = 4;
	localparam int SIZE_W    = 16;
	localparam int IDX_W     = 32;
	localparam int DIV_N_W   = 33;
	localparam int DIV_D_W   = 17;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);
	localparam int DIM_W     = 2;
	localparam int CFG_IDX_W = 3;

	// register index fields: bit 2 picks the table, bits 1:0 the dimension
	localparam logic CFG_TBL_SRC = 1'b0;
	localparam logic CFG_TBL_DST = 1'b1;

	typedef logic [SIZE_W-1:0] size_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             err;
	} q_item_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic               busy;
		logic [DIV_N_W-1:0] quot;
		logic [DIV_D_W-1:0] rem;
	} div_rsp_t;

	// outer dimensions beyond MAX_DIMS behave as extent 1
	function automatic size_t eff_size(input logic [DIM_W-1:0] k, input size_t v);
		size_t r;
		r = v;
		if (32'(k) < NUM_DIMS - MAX_DIMS) begin
			r = size_t'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[src/nearest_resize_index_map.sv]
// ----------------------------------------------------------------------------
// nearest_resize_index_map
// Nearest-neighbor (half-pixel) resize address generator, up to four dims.
// ----------------------------------------------------------------------------
// A destination index out of range returns index_error with source_index 0;
// it is loaded into the output register straight from the queue and does
// not enter the engine. An in-range index runs eight divisions (four to
// split the index, four to map coordinates) one after another on a single
// shared serial divider, each with a start step, 33 quotient bits and a
// handoff step, plus four accumulate steps and a step each to take the
// item and hand it over. The engine takes no new item until it has handed
// the last one over. A two-entry queue lets the input take further beats
// while the engine works, and the output register holds a finished beat
// while the engine works on its next item, which waits at hand-over until
// the register is free. After a register write the input stays not-ready
// while the element count is recomputed.
`default_nettype none
module nearest_resize_index_map import nrim_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [SIZE_W-1:0]    wr_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [IDX_W-1:0]     dest_index,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [IDX_W-1:0]          source_index,
	output logic                      index_error
);
	size_t   src_size_q [NUM_DIMS];
	size_t   dst_size_q [NUM_DIMS];
	logic    push, pop, q_full, q_not_empty;
	q_item_t push_item, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				src_size_q[i] <= size_t'(1);
				dst_size_q[i] <= size_t'(1);
			end
		end else if (wr_en) begin
			if (wr_index[CFG_IDX_W-1] == CFG_TBL_SRC) begin
				src_size_q[wr_index[DIM_W-1:0]] <= wr_data;
			end else begin
				dst_size_q[wr_index[DIM_W-1:0]] <= wr_data;
			end
		end
	end

	nrim_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.dst_size   (dst_size_q),
		.cfg_write  (wr_en),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.dest_index (dest_index),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	nrim_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	nrim_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_size     (src_size_q),
		.dst_size     (dst_size_q),
		.head         (head),
		.q_not_empty  (q_not_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.source_index (source_index),
		.index_error  (index_error)
	);
endmodule
`default_nettype wire

[src/nrim_fifo.sv]
// ----------------------------------------------------------------------------
// nrim_fifo
// Two-entry queue between the classifier and the address engine.
// ----------------------------------------------------------------------------
`default_nettype none
module nrim_fifo import nrim_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire q_item_t push_item,
	input  wire logic    pop,
	output q_item_t      head,
	output logic         not_empty,
	output logic         full
);
	q_item_t    mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);

	`include "nearest_resize_index_map_assert.svh"
	`NRIM_ASSERT(a_no_overflow, !(push && full && !pop), "push into full queue")
	`NRIM_ASSERT(a_no_underflow, !(pop && !not_empty), "pop from empty queue")
	`NRIM_ASSERT(a_cnt_range, cnt_q != 2'd3, "queue count out of range")
endmodule
`default_nettype wire

[src/nrim_front.sv]
// ----------------------------------------------------------------------------
// nrim_front
// Accepts destination indices and flags those at or above the element count.
// ----------------------------------------------------------------------------
`default_nettype none
module nrim_front import nrim_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire size_t            dst_size [NUM_DIMS],
	input  wire logic             cfg_write,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [IDX_W-1:0] dest_index,
	input  wire logic             q_full,
	output logic                  push,
	output q_item_t               push_item
);
	logic [2*SIZE_W-1:0] p01_s1, p23_s1;
	logic [4*SIZE_W-1:0] count_s2;
	logic [1:0]          settle_q;

	// element count, two stages after the extents
	always_ff @(posedge clk) begin
		p01_s1   <= eff_size(2'd0, dst_size[0]) * eff_size(2'd1, dst_size[1]);
		p23_s1   <= eff_size(2'd2, dst_size[2]) * eff_size(2'd3, dst_size[3]);
		count_s2 <= p01_s1 * p23_s1;
	end

	// hold input off until the count has caught up with a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 2'd2;
		end else if (cfg_write) begin
			settle_q <= 2'd2;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	assign in_ready      = (settle_q == 2'd0) && !q_full;
	assign push          = in_valid && in_ready;
	assign push_item.idx = dest_index;
	assign push_item.err = ({{(4*SIZE_W-IDX_W){1'b0}}, dest_index} >= count_s2);
endmodule
`default_nettype wire

[src/nrim_div.sv]
// ----------------------------------------------------------------------------
// nrim_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module nrim_div import nrim_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   rem_q, dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIV_D_W:0]     trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_N_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
			rem_q <= fits ? DIV_D_W'(trial - {1'b0, dvs_q}) : trial[DIV_D_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				cnt_q <= DIV_CNT_W'(DIV_N_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = (cnt_q != '0);
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

	`include "nearest_resize_index_map_assert.svh"
	`NRIM_ASSERT(a_start_idle, !(req.start && cnt_q != '0), "divider restarted while busy")
	`NRIM_ASSERT_NEXT(a_done_after, cnt_q == DIV_CNT_W'(1), done_q, "divider done missing")
	`NRIM_ASSERT(a_done_quiet, !(done_q && cnt_q != '0), "done while still iterating")
endmodule
`default_nettype wire

[src/nrim_back.sv]
// ----------------------------------------------------------------------------
// nrim_back
// Address engine: splits the index, maps each coordinate, recombines; flagged beats go straight to the output.
// ----------------------------------------------------------------------------
`default_nettype none
module nrim_back import nrim_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire size_t             src_size [NUM_DIMS],
	input  wire size_t             dst_size [NUM_DIMS],
	input  wire q_item_t           head,
	input  wire logic              q_not_empty,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [IDX_W-1:0]       source_index,
	output logic                   index_error
);
	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_SPLIT_GO  = 7'b0000010,
		ST_SPLIT_WT  = 7'b0000100,
		ST_MAP_GO    = 7'b0001000,
		ST_MAP_WT    = 7'b0010000,
		ST_ACC       = 7'b0100000,
		ST_DONE      = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [DIM_W-1:0] k_q;
	logic [IDX_W-1:0] rest_q, acc_q;
	size_t            coord_q [NUM_DIMS];
	size_t            mapped_q;
	logic             out_valid_q, out_err_q;
	logic [IDX_W-1:0] out_src_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	size_t                src_k, dst_k;
	logic                 out_free;
	logic                 out_load;
	logic [IDX_W+SIZE_W-1:0] acc_prod;

	nrim_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign src_k    = eff_size(k_q, src_size[k_q]);
	assign dst_k    = eff_size(k_q, dst_size[k_q]);
	assign out_free = !out_valid_q || out_ready;
	assign acc_prod = acc_q * src_k;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {1'b0, rest_q};
		div_req.divisor  = {1'b0, dst_k};
		case (state_q)
			ST_SPLIT_GO: begin
				div_req.start = 1'b1;
			end
			ST_MAP_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {coord_q[k_q], 1'b1} * src_k;
				div_req.divisor  = {dst_k, 1'b0};
			end
			default: begin
			end
		endcase
	end

	assign pop = (state_q == ST_IDLE) && q_not_empty && (!head.err || out_free);

	// load the output register with a flagged beat or a finished address
	assign out_load = pop ? head.err : ((state_q == ST_DONE) && out_free);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rest_q <= head.idx;
				k_q    <= DIM_W'(NUM_DIMS - 1);
				acc_q  <= '0;
			end
			ST_SPLIT_WT: begin
				if (div_rsp.done) begin
					coord_q[k_q] <= div_rsp.rem[SIZE_W-1:0];
					rest_q       <= div_rsp.quot[IDX_W-1:0];
					if (k_q != '0) k_q <= k_q - DIM_W'(1);
				end
			end
			ST_MAP_WT: begin
				if (div_rsp.done) mapped_q <= div_rsp.quot[SIZE_W-1:0];
			end
			ST_ACC: begin
				acc_q <= acc_prod[IDX_W-1:0] + {{(IDX_W-SIZE_W){1'b0}}, mapped_q};
				if (k_q != DIM_W'(NUM_DIMS - 1)) k_q <= k_q + DIM_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_err_q   <= 1'b0;
			out_src_q   <= '0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.err) begin
							out_err_q   <= 1'b1;
							out_src_q   <= '0;
						end else begin
							state_q <= ST_SPLIT_GO;
						end
					end
				end
				ST_SPLIT_GO: state_q <= ST_SPLIT_WT;
				ST_SPLIT_WT: begin
					if (div_rsp.done) state_q <= (k_q == '0) ? ST_MAP_GO : ST_SPLIT_GO;
				end
				ST_MAP_GO: state_q <= ST_MAP_WT;
				ST_MAP_WT: begin
					if (div_rsp.done) state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= (k_q == DIM_W'(NUM_DIMS - 1)) ? ST_DONE : ST_MAP_GO;
				end
				ST_DONE: begin
					if (out_free) begin
						out_err_q   <= 1'b0;
						out_src_q   <= acc_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign source_index = out_src_q;
	assign index_error  = out_err_q;

	`include "nearest_resize_index_map_assert.svh"
	`NRIM_ASSERT(a_err_zero, !(out_valid_q && out_err_q && out_src_q != '0), "flagged beat nonzero")
	`NRIM_ASSERT(a_start_free, !(div_req.start && div_rsp.busy), "divider started while busy")
	`NRIM_ASSERT(a_pop_idle, !(pop && state_q != ST_IDLE), "pop outside idle")
endmodule
`default_nettype wire
